FILE: rtl/core/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// shared widths, operation codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

   localparam int NUM_SPINS_DEF      = 1024;
   localparam int MAX_NEIGHBOURS_DEF = 16;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 10;
   localparam int SLOT_W  = 4;
   localparam int TOTAL_W = 15;

   localparam logic [OP_W-1:0] OP_LOAD_SPIN  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_ENTRY = 2'd1;
   localparam logic [OP_W-1:0] OP_RECOMPUTE  = 2'd2;
   localparam logic [OP_W-1:0] OP_FLIP       = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear_wr;   // zero one spin and count entry, step the sweep
      logic item_load;  // capture the request fields
      logic spin_wr;    // spin load
      logic entry_wr;   // neighbour entry load
      logic walk_init;  // start a flip or recompute walk
      logic hdr_cap;    // take count and spin of the walked spin
      logic issue;      // read the next table entry
      logic next_spin;  // advance the recompute walk
      logic finish;     // close a recompute
      logic rsp_load;   // put the total in the output register
   } spt_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            spin_ok;
      logic            clear_last;
      logic            walk_end;
      logic            last_spin;
      logic            pipe_empty;
      logic            rsp_free;
   } spt_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/spt_ram.sv
// ----------------------------------------------------------------------------
// spt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module spt_ram #(
   parameter int  WIDTH = 1,
   parameter int  DEPTH = 2,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/spt_ctrl.sv
// ----------------------------------------------------------------------------
// spt_ctrl
// sequencer: clear sweep, item dispatch, neighbour walks and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module spt_ctrl import spt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output spt_cmd_type       cmd,
   input  wire spt_stat_type stat
);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_DISPATCH = 3'd2;
   localparam logic [2:0] ST_HDR      = 3'd3;
   localparam logic [2:0] ST_CAP      = 3'd4;
   localparam logic [2:0] ST_WALK     = 3'd5;
   localparam logic [2:0] ST_DRAIN    = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.item_load = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.op)
               OP_LOAD_SPIN: begin
                  cmd.spin_wr = 1'b1;
                  state_in    = ST_DONE;
               end
               OP_LOAD_ENTRY: begin
                  cmd.entry_wr = 1'b1;
                  state_in     = ST_DONE;
               end
               OP_RECOMPUTE: begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_HDR;
               end
               OP_FLIP: begin
                  if (stat.spin_ok) begin
                     cmd.walk_init = 1'b1;
                     state_in      = ST_HDR;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_HDR: begin
            state_in = ST_CAP;
         end
         ST_CAP: begin
            cmd.hdr_cap = 1'b1;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            if (!stat.walk_end) begin
               cmd.issue = 1'b1;
            end else if (stat.op == OP_RECOMPUTE && !stat.last_spin) begin
               cmd.next_spin = 1'b1;
               state_in      = ST_HDR;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (stat.pipe_empty) begin
               cmd.finish = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/spt_datapath.sv
// ----------------------------------------------------------------------------
// spt_datapath
// spin, count and neighbour memories, walk counters, product pipeline,
// running total and output register
// ----------------------------------------------------------------------------
`default_nettype none

module spt_datapath import spt_pkg::*; #(
   parameter int NUM_SPINS      = NUM_SPINS_DEF,
   parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire spt_cmd_type          cmd,
   output spt_stat_type              stat,
   input  wire logic [OP_W-1:0]      req_op,
   input  wire logic [IDX_W-1:0]     req_spin,
   input  wire logic [SLOT_W-1:0]    req_slot,
   input  wire logic [IDX_W-1:0]     req_nb,
   input  wire logic                 req_sign,
   input  wire logic                 csr_we,
   input  wire logic                 csr_wdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [TOTAL_W-1:0]   rsp_total
);

   localparam int SAW  = $clog2(NUM_SPINS);
   localparam int NENT = NUM_SPINS * MAX_NEIGHBOURS;
   localparam int TAW  = (NENT > 1) ? $clog2(NENT) : 1;
   localparam int CW   = $clog2(MAX_NEIGHBOURS + 1);
   localparam int TW   = IDX_W + 1;
   localparam int SUMW = $clog2(NENT + 1) + 1;

   // item fields
   logic [OP_W-1:0]   op_ff;
   logic [IDX_W-1:0]  spin_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [IDX_W-1:0]  nb_ff;
   logic              sign_ff;

   logic method_mode_ff;

   // walk control
   logic [SAW-1:0] ws_ff;
   logic [SAW-1:0] ws_in;
   logic [CW-1:0]  k_ff;
   logic [CW-1:0]  k_in;
   logic [CW-1:0]  cnt_ff;
   logic [CW-1:0]  cnt_in;
   logic           sa_ff;
   logic           sa_in;

   // product pipeline
   logic p1_valid_ff;
   logic p1_sa_ff;
   logic p2_valid_ff;
   logic p2_sa_ff;
   logic p2_w_ff;

   logic signed [SUMW-1:0] sum_ff;
   logic signed [SUMW-1:0] sum_in;
   logic signed [SUMW-1:0] half_sum;
   logic [TOTAL_W-1:0]     total_ff;
   logic [TOTAL_W-1:0]     total_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff;

   logic is_flip;
   logic is_rec;
   logic spin_ok;
   logic entry_ok;
   logic neg;

   // memory ports
   logic           spin_we;
   logic [SAW-1:0] spin_waddr;
   logic           spin_wdata;
   logic           spin_a_rdata;
   logic           spin_b_rdata;
   logic [SAW-1:0] spin_b_raddr;
   logic           cnt_we;
   logic [CW-1:0]  cnt_wdata;
   logic [CW-1:0]  cnt_rdata;
   logic           tab_we;
   logic [TAW-1:0] tab_waddr;
   logic [TW-1:0]  tab_wdata;
   logic [TAW-1:0] tab_raddr;
   logic [TW-1:0]  tab_rdata;

   assign is_flip  = (op_ff == OP_FLIP);
   assign is_rec   = (op_ff == OP_RECOMPUTE);
   assign spin_ok  = (32'(spin_ff) < NUM_SPINS);
   assign entry_ok = spin_ok && (32'(nb_ff) < NUM_SPINS)
                     && (32'(slot_ff) < MAX_NEIGHBOURS);

   // spin store write port: clear sweep, spin load, or the flipped spin
   always_comb begin
      spin_we    = 1'b0;
      spin_waddr = ws_ff;
      spin_wdata = 1'b0;
      if (cmd.clear_wr) begin
         spin_we = 1'b1;
      end else if (cmd.spin_wr) begin
         spin_we    = spin_ok;
         spin_waddr = SAW'(32'(spin_ff));
         spin_wdata = sign_ff;
      end else if (cmd.hdr_cap && is_flip) begin
         spin_we    = 1'b1;
         spin_wdata = spin_a_rdata ^ 1'b1;
      end
   end

   assign cnt_we    = cmd.clear_wr || (cmd.entry_wr && entry_ok);
   assign cnt_wdata = cmd.clear_wr ? '0 : CW'(32'(slot_ff) + 1);

   assign tab_we    = cmd.entry_wr && entry_ok;
   assign tab_waddr = TAW'(32'(spin_ff) * MAX_NEIGHBOURS + 32'(slot_ff));
   assign tab_wdata = {sign_ff, nb_ff};
   assign tab_raddr = TAW'(32'(ws_ff) * MAX_NEIGHBOURS + 32'(k_ff));

   assign spin_b_raddr = SAW'(32'(tab_rdata[IDX_W-1:0]));

   spt_ram #(.WIDTH(1), .DEPTH(NUM_SPINS)) u_spin_a_ram (
      .clock   (clock),
      .wr_en   (spin_we),
      .wr_addr (spin_waddr),
      .wr_data (spin_wdata),
      .rd_addr (ws_ff),
      .rd_data (spin_a_rdata)
   );

   // second copy of the spin store for the neighbour side
   spt_ram #(.WIDTH(1), .DEPTH(NUM_SPINS)) u_spin_b_ram (
      .clock   (clock),
      .wr_en   (spin_we),
      .wr_addr (spin_waddr),
      .wr_data (spin_wdata),
      .rd_addr (spin_b_raddr),
      .rd_data (spin_b_rdata)
   );

   spt_ram #(.WIDTH(CW), .DEPTH(NUM_SPINS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cmd.clear_wr ? ws_ff : SAW'(32'(spin_ff))),
      .wr_data (cnt_wdata),
      .rd_addr (ws_ff),
      .rd_data (cnt_rdata)
   );

   spt_ram #(.WIDTH(TW), .DEPTH(NENT)) u_table_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata)
   );

   // walk counters
   always_comb begin
      ws_in  = ws_ff;
      k_in   = k_ff;
      cnt_in = cnt_ff;
      sa_in  = sa_ff;
      if (cmd.clear_wr || cmd.next_spin) begin
         ws_in = ws_ff + SAW'(1);
      end else if (cmd.walk_init) begin
         ws_in = is_rec ? '0 : SAW'(32'(spin_ff));
      end
      if (cmd.hdr_cap) begin
         k_in   = '0;
         cnt_in = cnt_rdata;
         sa_in  = spin_a_rdata ^ is_flip;
      end else if (cmd.issue) begin
         k_in = k_ff + CW'(1);
      end
   end

   // sign of weight * s[a] * s[b]
   assign neg = p2_sa_ff ^ spin_b_rdata ^ (method_mode_ff & p2_w_ff);

   assign half_sum = signed'(sum_ff + SUMW'(sum_ff[SUMW-1])) >>> 1;

   always_comb begin
      sum_in   = sum_ff;
      total_in = total_ff;
      if (cmd.walk_init) begin
         sum_in = '0;
      end else if (p2_valid_ff) begin
         if (is_rec) begin
            sum_in = neg ? sum_ff - SUMW'(1) : sum_ff + SUMW'(1);
         end else begin
            total_in = total_ff + (neg ? {{(TOTAL_W-1){1'b1}}, 1'b0}
                                       : TOTAL_W'(2));
         end
      end
      if (cmd.finish && is_rec) begin
         total_in = TOTAL_W'(half_sum);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff          <= '0;
         k_ff           <= '0;
         cnt_ff         <= '0;
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         total_ff       <= '0;
         method_mode_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ws_ff       <= ws_in;
         k_ff        <= k_in;
         cnt_ff      <= cnt_in;
         p1_valid_ff <= cmd.issue;
         p2_valid_ff <= p1_valid_ff;
         total_ff    <= total_in;
         if (csr_we) begin
            method_mode_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         op_ff   <= req_op;
         spin_ff <= req_spin;
         slot_ff <= req_slot;
         nb_ff   <= req_nb;
         sign_ff <= req_sign;
      end
      if (cmd.rsp_load) begin
         rsp_total_ff <= total_ff;
      end
      sa_ff    <= sa_in;
      sum_ff   <= sum_in;
      p1_sa_ff <= sa_ff;
      p2_sa_ff <= p1_sa_ff;
      p2_w_ff  <= tab_rdata[IDX_W];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_total  = rsp_total_ff;

   assign stat.op         = op_ff;
   assign stat.spin_ok    = spin_ok;
   assign stat.clear_last = (32'(ws_ff) == NUM_SPINS - 1);
   assign stat.walk_end   = (k_ff == cnt_ff);
   assign stat.last_spin  = (32'(ws_ff) == NUM_SPINS - 1);
   assign stat.pipe_empty = !p1_valid_ff && !p2_valid_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

FILE: rtl/core/spin_pair_correlation_tracker.sv
// ----------------------------------------------------------------------------
// spin_pair_correlation_tracker
// spin store with per-spin neighbour lists and a running pair correlation
// total, updated by flips and full recomputes
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata spin, slot, neighbour, sign;
//                                        tuser op
//   rsp      out  rsp_tvalid/rsp_tready  tdata total
//   csr      in   csr_we                 csr_wdata method_mode
//
// one item at a time. spin and entry loads go from accept through dispatch to the
// output register; a flip walks the spin's neighbour list, one neighbour entry per cycle
// through the table memory, and a recompute walks the lists of all spins in turn.
// after reset a clearing pass over all NUM_SPINS entries zeroes spins and counts;
// req_tready stays low meanwhile. a held result in the output register does
// not block the next accept, only the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module spin_pair_correlation_tracker import spt_pkg::*; #(
   parameter int NUM_SPINS      = NUM_SPINS_DEF,
   parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // spin_index, slot_index, neighbour_index, sign_bit
   input  wire logic [1:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // total
   input  wire logic        csr_we,
   input  wire logic        csr_wdata
);

   spt_cmd_type        cmd;
   spt_stat_type       stat;
   logic [TOTAL_W-1:0] rsp_total;

   spt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   spt_datapath #(
      .NUM_SPINS      (NUM_SPINS),
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_spin   (req_tdata[9:0]),
      .req_slot   (req_tdata[13:10]),
      .req_nb     (req_tdata[23:14]),
      .req_sign   (req_tdata[24]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_total  (rsp_total)
   );

   assign rsp_tdata = {1'b0, rsp_total};

endmodule

`default_nettype wire

FILE: rtl/core/spt_checker.sv
// ----------------------------------------------------------------------------
// spt_checker
// port-level checks on sequencing and output holding
// ----------------------------------------------------------------------------
`default_nettype none

module spt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // clearing pass blocks input right after reset
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("input accepted during clearing pass");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while busy");

   // no response while an item is only just taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   // padding bit of the total stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[15])
      else $error("padding bit set in result");

endmodule

bind spin_pair_correlation_tracker spt_checker u_spt_checker (.*);

`default_nettype wire

FILE: verif/tb_spin_pair_correlation_tracker.sv
// ----------------------------------------------------------------------------
// tb_spin_pair_correlation_tracker
// self-checking bench for the spin pair correlation tracker: a scoreboard
// mirrors spins, neighbour lists and the running total, predicts the total
// returned for every item, and compares it with what comes out of the block
// under random idling on the request and response streams in both weight modes
// ----------------------------------------------------------------------------
`default_nettype none

module tb_spin_pair_correlation_tracker import spt_pkg::*;;

   localparam int    NSPIN      = NUM_SPINS_DEF;
   localparam int    NSLOT      = MAX_NEIGHBOURS_DEF;
   localparam int    WIN        = 12;
   localparam int    PHASE_ITEMS = 240;
   localparam longint TIMEOUT_TU = 60_000_000;

   typedef enum {TOTAL_MATCH, TOTAL_WRONG, TOTAL_UNEXPECTED} check_outcome_type;

   class correlation_board;
      bit              spin_neg [NSPIN];
      bit [IDX_W-1:0]  link_to  [NSPIN*NSLOT];
      bit              link_neg [NSPIN*NSLOT];
      int              link_cnt [NSPIN];
      bit [TOTAL_W-1:0] total;
      bit              weighted;
      bit [TOTAL_W-1:0] pending_totals [$];

      // set when weight * s[a] * s[b] is -1
      function bit pair_neg(input int a, input int e);
         bit w;
         w = weighted ? link_neg[e] : 1'b0;
         return spin_neg[a] ^ spin_neg[link_to[e]] ^ w;
      endfunction

      function void sum_all();
         int sum;
         sum = 0;
         for (int a = 0; a < NSPIN; a++) begin
            for (int k = 0; k < link_cnt[a]; k++) begin
               if (pair_neg(a, a*NSLOT + k)) sum = sum - 1;
               else sum = sum + 1;
            end
         end
         // int division truncates toward zero
         total = TOTAL_W'(sum / 2);
      endfunction

      function void flip_spin(input int a);
         spin_neg[a] = ~spin_neg[a];
         for (int k = 0; k < link_cnt[a]; k++) begin
            if (pair_neg(a, a*NSLOT + k)) total = total - TOTAL_W'(2);
            else total = total + TOTAL_W'(2);
         end
      endfunction

      function void note_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] spin,
                              input logic [SLOT_W-1:0] slot,
                              input logic [IDX_W-1:0] nb, input logic sgn);
         case (op)
            OP_LOAD_SPIN: begin
               spin_neg[spin] = sgn;
            end
            OP_LOAD_ENTRY: begin
               link_to[spin*NSLOT + slot]  = nb;
               link_neg[spin*NSLOT + slot] = sgn;
               link_cnt[spin] = slot + 1;
            end
            OP_RECOMPUTE: begin
               sum_all();
            end
            default: begin
               flip_spin(int'(spin));
            end
         endcase
         pending_totals.push_back(total);
      endfunction

      function check_outcome_type check_total(input bit [TOTAL_W-1:0] got,
                                              output bit [TOTAL_W-1:0] want);
         want = '0;
         if (pending_totals.size() == 0) return TOTAL_UNEXPECTED;
         want = pending_totals.pop_front();
         return (got == want) ? TOTAL_MATCH : TOTAL_WRONG;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // spin_index, slot_index, neighbour_index, sign_bit
   logic [1:0]  req_tuser = '0;   // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // total
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;

   correlation_board board;

   int error_count;
   int n_checked;
   int op_seen [4];

   // generator view of which slots hold data, so no unwritten entry is read
   bit slot_done [NSPIN][NSLOT];
   int first_gap [NSPIN];
   int list_len  [NSPIN];

   int tx_calm_left;
   bit tx_calm;
   int rx_calm_left;
   bit rx_calm;
   int rx_stall_left;

   check_outcome_type outcome;
   bit [TOTAL_W-1:0]  want_total;

   spin_pair_correlation_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // response side back-pressure, with calm stretches of no stall
   always @(posedge clock) begin
      if (rx_calm_left > 0) begin
         rx_calm_left--;
      end else begin
         rx_calm = ~rx_calm;
         rx_calm_left = $urandom_range(50, 300);
      end
      if (rx_calm) begin
         rsp_tready <= 1'b1;
      end else if (rx_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rx_stall_left--;
      end else if ($urandom_range(0, 99) < 30) begin
         rsp_tready <= 1'b0;
         rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // results are checked before the item of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            outcome = board.check_total(rsp_tdata[TOTAL_W-1:0], want_total);
            n_checked++;
            if (outcome == TOTAL_UNEXPECTED)
               flag_mismatch($sformatf("total %0d with no item pending",
                                       $signed(rsp_tdata[TOTAL_W-1:0])));
            else if (outcome == TOTAL_WRONG)
               flag_mismatch($sformatf("total %0d, expected %0d",
                                       $signed(rsp_tdata[TOTAL_W-1:0]),
                                       $signed(want_total)));
         end
         if (req_tvalid && req_tready) begin
            op_seen[req_tuser]++;
            board.note_item(req_tuser, req_tdata[9:0], req_tdata[13:10],
                            req_tdata[23:14], req_tdata[24]);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (tx_calm_left > 0) begin
         tx_calm_left--;
      end else begin
         tx_calm = ~tx_calm;
         tx_calm_left = $urandom_range(20, 80);
      end
      if (tx_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // valid stays high across back-to-back items, lowered only for a gap or a drain
   task automatic send_item(input logic [OP_W-1:0] op, input int spin, input int slot,
                            input int nb, input logic sgn);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, sgn, IDX_W'(nb), SLOT_W'(slot), IDX_W'(spin)};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_entry(input int s, input int k, input int nb, input bit w);
      slot_done[s][k] = 1'b1;
      while (first_gap[s] < NSLOT && slot_done[s][first_gap[s]]) first_gap[s]++;
      list_len[s] = k + 1;
      send_item(OP_LOAD_ENTRY, s, k, nb, w);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_totals.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      board.weighted = m;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int any_slot();
      return $urandom_range(0, NSLOT-1);
   endfunction

   task automatic run_phase(input bit mode, input int n_items);
      int issued;
      int r;
      int a;
      int b;
      int s;
      int base;
      bit w;
      drain_results();
      write_mode(mode);
      base = $urandom_range(0, NSPIN-WIN);
      issued = 0;
      while (issued < n_items) begin
         r = $urandom_range(0, 99);
         a = base + $urandom_range(0, WIN-1);
         b = base + $urandom_range(0, WIN-1);
         w = 1'($urandom_range(0, 1));
         if (r < 30 && list_len[a] < NSLOT && list_len[b] < NSLOT) begin
            // symmetric pair appended to both lists
            load_entry(a, list_len[a], b, w);
            issued++;
            if (a != b) begin
               load_entry(b, list_len[b], a, w);
               issued++;
            end
         end else if (r < 40) begin
            s = ($urandom_range(0, 1) == 0) ? a : $urandom_range(0, NSPIN-1);
            load_entry(s, $urandom_range(0, (first_gap[s] > NSLOT-1) ? NSLOT-1
                                                                     : first_gap[s]),
                       $urandom_range(0, NSPIN-1), w);
            issued++;
         end else if (r < 55) begin
            s = ($urandom_range(0, 1) == 0) ? a : $urandom_range(0, NSPIN-1);
            send_item(OP_LOAD_SPIN, s, any_slot(), $urandom_range(0, NSPIN-1), w);
            issued++;
         end else if (r < 57) begin
            send_item(OP_RECOMPUTE, $urandom_range(0, NSPIN-1), any_slot(),
                      $urandom_range(0, NSPIN-1), w);
            issued++;
         end else begin
            s = ($urandom_range(0, 3) != 0) ? a : $urandom_range(0, NSPIN-1);
            send_item(OP_FLIP, s, any_slot(), $urandom_range(0, NSPIN-1), w);
            issued++;
         end
         if ($urandom_range(0, 199) == 0) drain_results();
      end
   endtask

   initial begin
      #(TIMEOUT_TU);
      $display("tb_spin_pair_correlation_tracker NOT OK");
      $finish;
   end

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      // directed: extreme indexes, a full list with self and end neighbours,
      // every op, loads leaving the total alone, flip of a spin with no list
      send_item(OP_LOAD_SPIN, NSPIN-1, 0, 0, 1'b1);
      send_item(OP_LOAD_SPIN, 0, NSLOT-1, NSPIN-1, 1'b0);
      for (int k = 0; k < NSLOT; k++)
         load_entry(NSPIN-1, k, (k == 0) ? 0 : (k == 1) ? NSPIN-1 : k*61, k[0]);
      load_entry(0, 0, NSPIN-1, 1'b1);
      send_item(OP_RECOMPUTE, 0, 0, 0, 1'b0);
      send_item(OP_FLIP, NSPIN-1, NSLOT-1, NSPIN-1, 1'b1);
      send_item(OP_FLIP, 0, 0, 0, 1'b0);
      send_item(OP_RECOMPUTE, NSPIN-1, NSLOT-1, NSPIN-1, 1'b1);
      send_item(OP_LOAD_SPIN, NSPIN-1, 0, 0, 1'b0);
      send_item(OP_FLIP, NSPIN/2, 0, 0, 1'b0);

      run_phase(1'b1, PHASE_ITEMS);
      run_phase(1'b0, PHASE_ITEMS);
      run_phase(1'b1, PHASE_ITEMS);
      run_phase(1'b0, PHASE_ITEMS);

      drain_results();
      repeat (40) @(posedge clock);

      $display("ran %0d spin loads, %0d entry loads, %0d recomputes, %0d flips",
               op_seen[OP_LOAD_SPIN], op_seen[OP_LOAD_ENTRY], op_seen[OP_RECOMPUTE],
               op_seen[OP_FLIP]);
      $display("%0d totals checked over both weight modes, %0d mismatches",
               n_checked, error_count);
      if (error_count == 0)
         $display("tb_spin_pair_correlation_tracker OK");
      else
         $display("tb_spin_pair_correlation_tracker NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/spt_pkg.sv
rtl/core/spt_ram.sv
rtl/core/spt_ctrl.sv
rtl/core/spt_datapath.sv
rtl/core/spin_pair_correlation_tracker.sv
rtl/core/spt_checker.sv
verif/tb_spin_pair_correlation_tracker.sv
